// File: hdl/rdms_pkg.sv
// Package for the robot drive mode supervisor.
// Holds register indexes, mode, direction and status codes, reset values.
// No dependencies.
`timescale 1ns / 1ps

package rdms_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 15;
   localparam int ReqDataWidth = 80;
   localparam int RspDataWidth = 40;

   localparam logic [CsrIndexWidth-1:0] CSR_OBSTACLE_THRESHOLD = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DRIVE_COMMAND = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ESCAPE_LIMIT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CAMERA_SPAN = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CAMERA_THIRD = 3'd4;

   localparam logic [11:0] THRESHOLD_RESET = 12'd1000;
   localparam logic [13:0] DRIVE_RESET = 14'd1000;
   localparam logic [3:0] ESCAPE_RESET = 4'd10;
   localparam logic [14:0] SPAN_RESET = 15'd1024;
   localparam logic [13:0] THIRD_RESET = 14'd341;

   localparam logic [1:0] MODE_OBSTACLE = 2'd0;
   localparam logic [1:0] MODE_REMOTE = 2'd1;
   localparam logic [1:0] MODE_CAMERA = 2'd2;

   localparam logic [3:0] DIR_FWD = 4'd0;
   localparam logic [3:0] DIR_LEFT = 4'd1;
   localparam logic [3:0] DIR_BACK = 4'd2;
   localparam logic [3:0] DIR_RIGHT = 4'd3;
   localparam logic [3:0] DIR_STOP = 4'd4;
   localparam logic [3:0] DIR_FWD_LEFT = 4'd5;
   localparam logic [3:0] DIR_FWD_RIGHT = 4'd6;
   localparam logic [3:0] DIR_BACK_LEFT = 4'd7;
   localparam logic [3:0] DIR_BACK_RIGHT = 4'd8;
   localparam logic [3:0] DIR_COUNT = 4'd9;

   localparam logic [2:0] CODE_INITIAL = 3'd0;
   localparam logic [2:0] CODE_FORWARD = 3'd1;
   localparam logic [2:0] CODE_TURN_G = 3'd2;
   localparam logic [2:0] CODE_TURN_D = 3'd3;
   localparam logic [2:0] CODE_NOT_SENSOR = 3'd4;

   localparam logic [1:0] SPEED_RESET = 2'd1;
   localparam logic [3:0] COUNT_TOP = 4'd15;

endpackage

// File: hdl/robot_drive_mode_supervisor.sv
// Robot drive mode supervisor: merges remote messages into its mode state and
// issues wheel speed commands each control tick.
// Depends on rdms_pkg.
`timescale 1ns / 1ps

// Usage: each item on the req_ channel is one control tick. It may carry a
// remote message (req_tuser high) that updates mode, direction, speed level
// and the camera target; the IR readings are used in obstacle mode. Each item
// gives exactly one item on the rsp_ channel with both wheel speed commands,
// the direction code, the current mode and the speed level.
// rsp_tvalid rises in the cycle after acceptance. Throughput is one item per
// cycle unless the receiver stalls: the whole tick is computed in one pass
// and loaded into the result register, which also updates the state registers.
// When the receiver stalls, the result register holds its item and req_tready
// drops until it is taken; a new item is accepted in the cycle the old one
// leaves. The csr_ channel writes the five setup registers and is always ready.
// Reset restores the setup registers and state to their default values and
// empties the result register.
module robot_drive_mode_supervisor (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: msg_mode[7:0], msg_direction[15:8], msg_speed[23:16],
   // target_x[39:24], target_y[55:40], ir_left[67:56], ir_right[79:68]
   input  logic [rdms_pkg::ReqDataWidth-1:0] req_tdata,
   // tuser: has_message[0]
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: left_speed[15:0], right_speed[31:16], dir_code[34:32],
   // mode_now[36:35], speed_now[38:37], zero[39]
   output logic [rdms_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rdms_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rdms_pkg::CsrDataWidth-1:0] csr_data
);
   import rdms_pkg::*;

   logic [11:0] threshold_ff;
   logic [13:0] drive_ff;
   logic [3:0] escape_ff;
   logic [14:0] span_ff;
   logic [13:0] third_ff;

   logic [1:0] mode_ff, mode_in;
   logic [3:0] direction_ff, direction_in;
   logic [1:0] speed_ff, speed_in;
   logic signed [15:0] tx_ff, tx_in;
   logic signed [15:0] ty_ff, ty_in;
   logic [3:0] count_ff, count_in;
   logic [2:0] code_ff, code_in;

   logic rsp_valid_ff;
   logic signed [15:0] left_ff, left_in;
   logic signed [15:0] right_ff, right_in;

   logic req_fire;
   logic signed [7:0] msg_mode, msg_direction, msg_speed;
   logic [11:0] ir_left, ir_right;
   logic signed [15:0] d_val, h_val, q_val;
   logic signed [15:0] rem_l, rem_r;
   logic signed [16:0] x_ext, y_ext, t_ext, s_ext, st_ext;
   logic [2:0] x_band, y_band;
   logic obstacle;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign msg_mode = req_tdata[7:0];
   assign msg_direction = req_tdata[15:8];
   assign msg_speed = req_tdata[23:16];
   assign ir_left = req_tdata[67:56];
   assign ir_right = req_tdata[79:68];

   assign d_val = $signed({2'b00, drive_ff});
   assign h_val = $signed({3'b000, drive_ff[13:1]});
   assign q_val = $signed({4'b0000, drive_ff[13:2]});

   always_comb begin
      mode_in = mode_ff;
      direction_in = direction_ff;
      speed_in = speed_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      if (req_tuser) begin
         if (msg_mode[7:2] == 6'd0 && msg_mode[1:0] != 2'd3) begin
            mode_in = msg_mode[1:0];
         end
         if (msg_direction[7:4] == 4'd0 && msg_direction[3:0] < DIR_COUNT) begin
            direction_in = msg_direction[3:0];
         end
         if (msg_speed[7:2] == 6'd0 && msg_speed[1:0] != 2'd0) begin
            speed_in = msg_speed[1:0];
         end
         tx_in = $signed(req_tdata[39:24]);
         ty_in = $signed(req_tdata[55:40]);
      end
   end

   always_comb begin
      unique case (direction_in)
         DIR_FWD: begin
            rem_l = h_val;
            rem_r = h_val;
         end
         DIR_LEFT: begin
            rem_l = -h_val;
            rem_r = h_val;
         end
         DIR_BACK: begin
            rem_l = -h_val;
            rem_r = -h_val;
         end
         DIR_RIGHT: begin
            rem_l = h_val;
            rem_r = -h_val;
         end
         DIR_FWD_LEFT: begin
            rem_l = q_val;
            rem_r = h_val;
         end
         DIR_FWD_RIGHT: begin
            rem_l = h_val;
            rem_r = q_val;
         end
         DIR_BACK_LEFT: begin
            rem_l = -h_val;
            rem_r = -q_val;
         end
         DIR_BACK_RIGHT: begin
            rem_l = -q_val;
            rem_r = -h_val;
         end
         default: begin
            rem_l = '0;
            rem_r = '0;
         end
      endcase
   end

   // Band flags per axis: bit 0 low third, bit 1 middle, bit 2 high third.
   assign x_ext = {tx_in[15], tx_in};
   assign y_ext = {ty_in[15], ty_in};
   assign t_ext = $signed({3'b000, third_ff});
   assign s_ext = $signed({2'b00, span_ff});
   assign st_ext = s_ext - t_ext;

   always_comb begin
      x_band[0] = x_ext > 17'sd0 && x_ext < t_ext;
      x_band[1] = x_ext > t_ext && x_ext < st_ext;
      x_band[2] = x_ext > st_ext && x_ext < s_ext;
      y_band[0] = y_ext > 17'sd0 && y_ext < t_ext;
      y_band[1] = y_ext > t_ext && y_ext < st_ext;
      y_band[2] = y_ext > st_ext && y_ext < s_ext;
   end

   assign obstacle = ir_left > threshold_ff || ir_right > threshold_ff;

   always_comb begin
      left_in = '0;
      right_in = '0;
      count_in = count_ff;
      code_in = code_ff;
      if (mode_in == MODE_REMOTE) begin
         code_in = CODE_NOT_SENSOR;
         count_in = '0;
         left_in = 16'(rem_l * $signed({1'b0, speed_in}));
         right_in = 16'(rem_r * $signed({1'b0, speed_in}));
      end else if (mode_in == MODE_OBSTACLE) begin
         if (obstacle) begin
            priority if (count_ff > escape_ff) begin
               left_in = d_val;
               right_in = -h_val;
               code_in = CODE_TURN_G;
            end else if (ir_left > ir_right && ir_left > threshold_ff) begin
               left_in = h_val;
               right_in = -h_val;
               code_in = CODE_TURN_G;
               if (!count_ff[0] && count_ff != COUNT_TOP) begin
                  count_in = count_ff + 4'd1;
               end
            end else if (ir_left < ir_right && ir_right > threshold_ff) begin
               left_in = -h_val;
               right_in = h_val;
               code_in = CODE_TURN_D;
               if (count_ff[0] && count_ff != COUNT_TOP) begin
                  count_in = count_ff + 4'd1;
               end
            end else begin
               left_in = '0;
               right_in = '0;
            end
         end else begin
            left_in = d_val;
            right_in = d_val;
            code_in = CODE_FORWARD;
            count_in = '0;
         end
      end else begin
         code_in = CODE_NOT_SENSOR;
         count_in = '0;
         priority if (x_band[1] && y_band[0]) begin
            left_in = d_val;
            right_in = d_val;
         end else if (x_band[2] && y_band[0]) begin
            left_in = d_val;
            right_in = h_val;
         end else if (x_band[0] && y_band[0]) begin
            left_in = h_val;
            right_in = d_val;
         end else if (x_band[1] && y_band[1]) begin
            left_in = '0;
            right_in = '0;
         end else if (x_band[2] && y_band[1]) begin
            left_in = d_val;
            right_in = -d_val;
         end else if (x_band[0] && y_band[1]) begin
            left_in = -d_val;
            right_in = d_val;
         end else if (x_band[1] && y_band[2]) begin
            left_in = -d_val;
            right_in = -d_val;
         end else if (x_band[2] && y_band[2]) begin
            left_in = -h_val;
            right_in = -d_val;
         end else if (x_band[0] && y_band[2]) begin
            left_in = -d_val;
            right_in = -h_val;
         end else begin
            left_in = '0;
            right_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         drive_ff <= DRIVE_RESET;
         escape_ff <= ESCAPE_RESET;
         span_ff <= SPAN_RESET;
         third_ff <= THIRD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OBSTACLE_THRESHOLD: threshold_ff <= csr_data[11:0];
            CSR_DRIVE_COMMAND: drive_ff <= csr_data[13:0];
            CSR_ESCAPE_LIMIT: escape_ff <= csr_data[3:0];
            CSR_CAMERA_SPAN: span_ff <= csr_data[14:0];
            CSR_CAMERA_THIRD: third_ff <= csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OBSTACLE;
         direction_ff <= DIR_STOP;
         speed_ff <= SPEED_RESET;
         tx_ff <= '0;
         ty_ff <= '0;
         count_ff <= '0;
         code_ff <= CODE_INITIAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            mode_ff <= mode_in;
            direction_ff <= direction_in;
            speed_ff <= speed_in;
            tx_ff <= tx_in;
            ty_ff <= ty_in;
            count_ff <= count_in;
            code_ff <= code_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, speed_ff, mode_ff, code_ff, right_ff, left_ff};

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("Accepted item did not produce a result.");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Item accepted while result register was stalled.");

   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      speed_ff != 2'd0 && mode_ff != 2'd3)
      else $error("Speed level or mode holds an invalid value.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) || count_ff == 4'd0 ||
                         count_ff == $past(count_ff) + 4'd1))
      else $error("Oscillation count moved by more than one.");

   a_code_outside_obstacle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode_ff != MODE_OBSTACLE |-> code_ff == CODE_NOT_SENSOR &&
      count_ff == 4'd0)
      else $error("Direction code or count wrong outside obstacle mode.");

endmodule

// File: tb/sv/drive_command_checker.sv
// Checker for the drive mode supervisor: watches the request, result and csr channels,
// predicts each wheel command and compares it field by field with what the block returns.
// Depends on rdms_pkg.
`timescale 1ns / 1ps

module drive_command_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [rdms_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [rdms_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [rdms_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rdms_pkg::CsrDataWidth-1:0] csr_data,
   output int mismatches,
   output int results_done
);
   import rdms_pkg::*;

   localparam int BAND_LOW = 0;
   localparam int BAND_MID = 1;
   localparam int BAND_HIGH = 2;

   typedef struct packed {
      logic [11:0] ir_right;
      logic [11:0] ir_left;
      logic [15:0] target_y;
      logic [15:0] target_x;
      logic [7:0] speed;
      logic [7:0] direction;
      logic [7:0] mode;
   } tick_type;

   typedef struct packed {
      logic pad;
      logic [1:0] speed_now;
      logic [1:0] mode_now;
      logic [2:0] dir_code;
      logic [15:0] right_speed;
      logic [15:0] left_speed;
   } command_type;

   logic [11:0] obstacle_level;
   logic [13:0] drive_unit;
   logic [3:0] escape_after;
   logic [14:0] camera_span;
   logic [13:0] camera_third;

   logic [1:0] mode;
   logic [3:0] direction;
   logic [1:0] speed_level;
   logic signed [15:0] target_x;
   logic signed [15:0] target_y;
   logic [3:0] swing_count;
   logic [2:0] dir_code;

   command_type expected_q[$];
   int error_count = 0;
   int result_count = 0;

   function automatic bit in_band(input int v, input int band);
      int t;
      int s;
      t = int'(camera_third);
      s = int'(camera_span);
      case (band)
         BAND_LOW: return v > 0 && v < t;
         BAND_MID: return v > t && v < s - t;
         default: return v > s - t && v < s;
      endcase
   endfunction

   function automatic command_type next_command(input tick_type tick, input logic msg);
      command_type cmd;
      int d, h, q, l, r, m, dr, sp, s, k;
      int col [9];
      int row [9];
      int grid_left [9];
      int grid_right [9];
      d = int'(drive_unit);
      h = d / 2;
      q = h / 2;
      l = 0;
      r = 0;
      if (msg) begin
         m = int'($signed(tick.mode));
         dr = int'($signed(tick.direction));
         sp = int'($signed(tick.speed));
         if (m >= 0 && m <= int'(MODE_CAMERA)) mode = 2'(m);
         if (dr >= 0 && dr < int'(DIR_COUNT)) direction = 4'(dr);
         if (sp >= 1 && sp <= 3) speed_level = 2'(sp);
         target_x = tick.target_x;
         target_y = tick.target_y;
      end
      case (mode)
         MODE_REMOTE: begin
            dir_code = CODE_NOT_SENSOR;
            swing_count = '0;
            case (direction)
               DIR_FWD: begin l = h; r = h; end
               DIR_LEFT: begin l = -h; r = h; end
               DIR_BACK: begin l = -h; r = -h; end
               DIR_RIGHT: begin l = h; r = -h; end
               DIR_FWD_LEFT: begin l = q; r = h; end
               DIR_FWD_RIGHT: begin l = h; r = q; end
               DIR_BACK_LEFT: begin l = -h; r = -q; end
               DIR_BACK_RIGHT: begin l = -q; r = -h; end
               default: begin l = 0; r = 0; end
            endcase
            s = int'(speed_level);
            l = l * s;
            r = r * s;
         end
         MODE_OBSTACLE: begin
            if (tick.ir_left > obstacle_level || tick.ir_right > obstacle_level) begin
               if (swing_count > escape_after) begin
                  l = d;
                  r = -h;
                  dir_code = CODE_TURN_G;
               end else if (tick.ir_left > tick.ir_right && tick.ir_left > obstacle_level) begin
                  l = h;
                  r = -h;
                  dir_code = CODE_TURN_G;
                  if (!swing_count[0] && swing_count < COUNT_TOP) swing_count++;
               end else if (tick.ir_left < tick.ir_right && tick.ir_right > obstacle_level) begin
                  l = -h;
                  r = h;
                  dir_code = CODE_TURN_D;
                  if (swing_count[0] && swing_count < COUNT_TOP) swing_count++;
               end
            end else begin
               l = d;
               r = d;
               dir_code = CODE_FORWARD;
               swing_count = '0;
            end
         end
         default: begin
            col = '{BAND_MID, BAND_HIGH, BAND_LOW, BAND_MID, BAND_HIGH, BAND_LOW,
                    BAND_MID, BAND_HIGH, BAND_LOW};
            row = '{BAND_LOW, BAND_LOW, BAND_LOW, BAND_MID, BAND_MID, BAND_MID,
                    BAND_HIGH, BAND_HIGH, BAND_HIGH};
            grid_left = '{d, d, h, 0, d, -d, -d, -h, -d};
            grid_right = '{d, h, d, 0, -d, d, -d, -d, -h};
            dir_code = CODE_NOT_SENSOR;
            swing_count = '0;
            for (k = 0; k < 9; k++) begin
               if (in_band(int'(target_x), col[k]) && in_band(int'(target_y), row[k])) begin
                  l = grid_left[k];
                  r = grid_right[k];
                  break;
               end
            end
         end
      endcase
      cmd.pad = 1'b0;
      cmd.speed_now = speed_level;
      cmd.mode_now = mode;
      cmd.dir_code = dir_code;
      cmd.right_speed = 16'(r);
      cmd.left_speed = 16'(l);
      return cmd;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      command_type want;
      command_type got;
      if (reset) begin
         obstacle_level = THRESHOLD_RESET;
         drive_unit = DRIVE_RESET;
         escape_after = ESCAPE_RESET;
         camera_span = SPAN_RESET;
         camera_third = THIRD_RESET;
         mode = MODE_OBSTACLE;
         direction = DIR_STOP;
         speed_level = SPEED_RESET;
         target_x = '0;
         target_y = '0;
         swing_count = '0;
         dir_code = CODE_INITIAL;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OBSTACLE_THRESHOLD: obstacle_level = csr_data[11:0];
               CSR_DRIVE_COMMAND: drive_unit = csr_data[13:0];
               CSR_ESCAPE_LIMIT: escape_after = csr_data[3:0];
               CSR_CAMERA_SPAN: camera_span = csr_data[14:0];
               CSR_CAMERA_THIRD: camera_third = csr_data[13:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            result_count++;
            if (expected_q.size() == 0) begin
               $display("%0t: result %h arrived with none expected", $time, got);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("left_speed", want.left_speed, got.left_speed);
               check_field("right_speed", want.right_speed, got.right_speed);
               check_field("dir_code", 16'(want.dir_code), 16'(got.dir_code));
               check_field("mode_now", 16'(want.mode_now), 16'(got.mode_now));
               check_field("speed_now", 16'(want.speed_now), 16'(got.speed_now));
               check_field("zero bit", 16'(want.pad), 16'(got.pad));
            end
         end
         if (req_tvalid && req_tready) expected_q.push_back(next_command(req_tdata, req_tuser));
      end
      mismatches <= error_count;
      results_done <= result_count;
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the drive mode supervisor bench: clock, reset, request and csr stimulus,
// random result-side stalls and the final verdict.
// Depends on rdms_pkg, robot_drive_mode_supervisor and drive_command_checker.
`timescale 1ns / 1ps

module testbench;
   import rdms_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   int mismatches;
   int results_done;
   int sent_count = 0;
   int cfg_threshold = int'(THRESHOLD_RESET);
   int cfg_span = int'(SPAN_RESET);
   int cfg_third = int'(THIRD_RESET);
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit long_hold_req = 1'b0;

   robot_drive_mode_supervisor DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   drive_command_checker command_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatches(mismatches),
      .results_done(results_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_tick(input logic msg, input logic [7:0] mode, input logic [7:0] dir,
                            input logic [7:0] spd, input logic [15:0] tx, input logic [15:0] ty,
                            input logic [11:0] il, input logic [11:0] ir);
      if (!tx_calm && $urandom_range(3, 0) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(18, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= msg;
      req_tdata <= {ir, il, ty, tx, spd, dir, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_done != sent_count);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CsrDataWidth'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_setting(input int thr, input int drv, input int lim, input int spn,
                                input int thd, input bit spare);
      drain();
      write_reg(CSR_OBSTACLE_THRESHOLD, thr);
      write_reg(CSR_DRIVE_COMMAND, drv);
      write_reg(CSR_ESCAPE_LIMIT, lim);
      write_reg(CSR_CAMERA_SPAN, spn);
      write_reg(CSR_CAMERA_THIRD, thd);
      if (spare) write_reg(CSR_SPARE, int'($urandom));
      csr_valid <= 1'b0;
      cfg_threshold = thr;
      cfg_span = spn;
      cfg_third = thd;
   endtask

   function automatic logic [11:0] ir_above();
      return (cfg_threshold < 4095) ? 12'($urandom_range(4095, cfg_threshold + 1)) : 12'hFFF;
   endfunction

   function automatic int band_value(input int lo, input int hi);
      if (lo > hi || lo < 0) return lo;
      return int'($urandom_range(hi, lo));
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(9, 0))
         0, 1: return 16'(band_value(1, cfg_third - 1));
         2, 3, 4: return 16'(band_value(cfg_third + 1, cfg_span - cfg_third - 1));
         5, 6: return 16'(band_value(cfg_span - cfg_third + 1, cfg_span - 1));
         7: return ($urandom_range(1, 0) != 0) ? 16'(cfg_third) : 16'(cfg_span - cfg_third);
         8: return ($urandom_range(1, 0) != 0) ? 16'(cfg_span) : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Runs short sequences of ticks: obstacle runs, remote drives, camera tracking and noise.
   task automatic run_scenarios(input int count, input bit calm);
      int done, len, kind, i;
      logic msg;
      logic [7:0] mode, dir, spd;
      logic [15:0] tx, ty;
      logic [11:0] il, ir, hi, lo;
      done = 0;
      while (done < count) begin
         kind = int'($urandom_range(9, 0));
         len = int'($urandom_range(12, 3));
         tx_calm = calm || ($urandom_range(3, 0) == 0);
         for (i = 0; i < len; i++) begin
            msg = 1'($urandom_range(1, 0));
            mode = 8'($urandom);
            dir = 8'($urandom);
            spd = 8'($urandom);
            tx = 16'($urandom);
            ty = 16'($urandom);
            il = 12'($urandom);
            ir = 12'($urandom);
            case (kind)
               0, 1, 2, 3: begin
                  msg = (i == 0) || ($urandom_range(7, 0) == 0);
                  if (msg) mode = 8'(MODE_OBSTACLE);
                  case ($urandom_range(5, 0))
                     0: begin
                        il = 12'($urandom_range(cfg_threshold, 0));
                        ir = 12'($urandom_range(cfg_threshold, 0));
                     end
                     1, 2: begin
                        hi = ir_above();
                        lo = (hi > 0) ? 12'($urandom_range(hi - 1, 0)) : 12'h000;
                        il = i[0] ? lo : hi;
                        ir = i[0] ? hi : lo;
                     end
                     3: begin
                        il = ir_above();
                        ir = il;
                     end
                     4: begin
                        il = 12'(cfg_threshold);
                        ir = (cfg_threshold < 4095) ? 12'(cfg_threshold + 1) : 12'hFFF;
                     end
                     default: ;
                  endcase
               end
               4, 5: begin
                  msg = (i == 0) || ($urandom_range(3, 0) != 0);
                  if (i == 0 || $urandom_range(7, 0) != 0) mode = 8'(MODE_REMOTE);
                  if ($urandom_range(5, 0) != 0) begin
                     dir = 8'($urandom_range(DIR_BACK_RIGHT, DIR_FWD));
                  end
                  if ($urandom_range(5, 0) != 0) spd = 8'($urandom_range(3, 1));
               end
               6, 7: begin
                  msg = (i == 0) || ($urandom_range(3, 0) != 0);
                  if (i == 0 || $urandom_range(7, 0) != 0) mode = 8'(MODE_CAMERA);
                  tx = pick_coord();
                  ty = pick_coord();
               end
               default: ;
            endcase
            send_tick(msg, mode, dir, spd, tx, ty, il, ir);
         end
         done += len;
      end
   endtask

   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
         end else if (rx_calm || $urandom_range(2, 0) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(18, 1)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int i, spn, thd, phase;
      logic [3:0] k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Obstacle mode at reset settings: at threshold, left, right, equal, then the
      // left/right swing that ends in the escape turn.
      send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 12'd1000, 12'd1000);
      send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 12'hFFF, 12'h000);
      send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 12'h000, 12'hFFF);
      send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom), 12'hFFF, 12'hFFF);
      for (i = 0; i < 10; i++) begin
         send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom), i[0] ? 12'd1500 : 12'd2000, i[0] ? 12'd2000 : 12'd1500);
      end

      // Remote mode through every direction and speed level, then ignored message fields.
      for (k = DIR_FWD; k <= DIR_BACK_RIGHT; k++) begin
         send_tick(1'b1, 8'(MODE_REMOTE), 8'(k), 8'(k % 3 + 1), 16'h8000, 16'h7FFF,
                   12'hFFF, 12'h000);
      end
      send_tick(1'b1, 8'h80, 8'h7F, 8'h00, 16'hFFFF, 16'h0001, 12'hFFF, 12'h000);
      send_tick(1'b1, 8'(MODE_CAMERA + 1), 8'(DIR_COUNT), 8'd4, 16'd100, 16'd100,
                12'h000, 12'hFFF);

      // Camera grid: top left, centre, bottom right, a band edge and a point off the span.
      send_tick(1'b1, 8'(MODE_CAMERA), 8'hFF, 8'hFF, 16'd100, 16'd100, 12'h000, 12'h000);
      send_tick(1'b1, 8'(MODE_CAMERA), 8'hFF, 8'hFF, 16'd512, 16'd512, 12'h000, 12'h000);
      send_tick(1'b1, 8'(MODE_CAMERA), 8'hFF, 8'hFF, 16'd1000, 16'd900, 12'h000, 12'h000);
      send_tick(1'b1, 8'(MODE_CAMERA), 8'hFF, 8'hFF, 16'd341, 16'd100, 12'h000, 12'h000);
      send_tick(1'b1, 8'(MODE_CAMERA), 8'hFF, 8'hFF, 16'h8000, 16'h7FFF, 12'h000, 12'h000);

      run_scenarios(90, 1'b0);

      apply_setting(0, 16383, 0, 32767, 16383, 1'b0);
      long_hold_req = 1'b1;
      run_scenarios(40, 1'b1);
      run_scenarios(50, 1'b0);

      apply_setting(4095, 0, 14, 1, 1, 1'b1);
      run_scenarios(90, 1'b0);

      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            apply_setting(1500, 1, 3, 900, 300, 1'b0);
         end else begin
            spn = int'($urandom_range(32767, 1));
            thd = ($urandom_range(3, 0) != 0) ? spn / 3 : int'($urandom_range(16383, 1));
            if (thd < 1) thd = 1;
            if (thd > 16383) thd = 16383;
            apply_setting(int'($urandom_range(4095, 0)), int'($urandom_range(16383, 0)),
                          int'($urandom_range(14, 0)), spn, thd, 1'b0);
         end
         if (phase == 2) rx_calm = 1'b1;
         run_scenarios(90, phase == 2);
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && results_done == sent_count) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/rdms_pkg.sv
hdl/robot_drive_mode_supervisor.sv
tb/sv/drive_command_checker.sv
tb/sv/testbench.sv
